FILE: sv/pcmsp_pkg.sv
// Shared types, codes and defaults for the PCM sample packer.
package pcmsp_pkg;

   localparam int FRAC_BITS_DEFAULT   = 24;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FORMAT    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_HIGH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_LOW  = 3'd4;

   // output format codes
   localparam logic [2:0] FMT_U8     = 3'd0;
   localparam logic [2:0] FMT_S16_LE = 3'd1;
   localparam logic [2:0] FMT_S16_BE = 3'd2;
   localparam logic [2:0] FMT_S24_LE = 3'd3;
   localparam logic [2:0] FMT_S24_BE = 3'd4;
   localparam logic [2:0] FMT_S32_LE = 3'd5;
   localparam logic [2:0] FMT_S32_BE = 3'd6;

   localparam logic [2:0]         FORMAT_RESET    = FMT_S16_LE;
   localparam logic [31:0]        GAIN_RESET      = 32'd32768;
   localparam logic [7:0]         OFFSET_RESET    = 8'h80;
   localparam logic signed [31:0] CLIP_HIGH_RESET = 32'sd16777216;
   localparam logic signed [31:0] CLIP_LOW_RESET  = -32'sd16777216;

   localparam logic [7:0] PAD_BYTE  = 8'h00;
   localparam logic [7:0] SIGN_MASK = 8'h80;

   typedef struct packed {
      logic signed [31:0] sample_value;
      logic               block_end;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
      logic       block_end_out;
   } rsp_word_type;

   // one packed sample waiting for the serializer: bytes in send order
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      logic            block_end;
   } entry_type;

endpackage

FILE: sv/pcmsp_front.sv
// Front end: configuration registers, clamp, gain multiply and byte packing.
module pcmsp_front #(
   parameter int FRAC_BITS = pcmsp_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_en,
   input  logic [pcmsp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [pcmsp_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                   in_valid,
   input  pcmsp_pkg::req_word_type                in_word,
   output logic                                   wr_en,
   output pcmsp_pkg::entry_type                   wr_entry,
   output logic [1:0]                             inflight
);

   logic [2:0]         format_ff,    format_in;
   logic [31:0]        gain_ff,      gain_in;
   logic [7:0]         offset_ff,    offset_in;
   logic signed [31:0] clip_high_ff, clip_high_in;
   logic signed [31:0] clip_low_ff,  clip_low_in;

   logic        s1_valid_ff, s1_valid_in;
   logic        s1_neg_ff,   s1_neg_in;
   logic [31:0] s1_mag_ff,   s1_mag_in;
   logic        s1_bend_ff,  s1_bend_in;

   logic        s2_valid_ff, s2_valid_in;
   logic        s2_neg_ff,   s2_neg_in;
   logic [63:0] s2_prod_ff,  s2_prod_in;
   logic        s2_bend_ff,  s2_bend_in;

   logic signed [31:0] clamped;
   logic [63:0]        shifted;
   logic [31:0]        scaled;
   logic [7:0]         b0, b1, b2, b3, b2_sign;

   // register file
   always_comb begin
      format_in    = format_ff;
      gain_in      = gain_ff;
      offset_in    = offset_ff;
      clip_high_in = clip_high_ff;
      clip_low_in  = clip_low_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            pcmsp_pkg::CSR_FORMAT:    format_in    = csr_wdata[2:0];
            pcmsp_pkg::CSR_GAIN:      gain_in      = csr_wdata;
            pcmsp_pkg::CSR_OFFSET:    offset_in    = csr_wdata[7:0];
            pcmsp_pkg::CSR_CLIP_HIGH: clip_high_in = csr_wdata;
            pcmsp_pkg::CSR_CLIP_LOW:  clip_low_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 1: clamp, high limit wins when the limits cross
   always_comb begin
      if (in_word.sample_value > clip_high_ff) begin
         clamped = clip_high_ff;
      end else if (in_word.sample_value < clip_low_ff) begin
         clamped = clip_low_ff;
      end else begin
         clamped = in_word.sample_value;
      end
      s1_valid_in = in_valid;
      s1_neg_in   = clamped[31];
      s1_mag_in   = clamped[31] ? (~clamped + 32'd1) : clamped;
      s1_bend_in  = in_word.block_end;
   end

   // stage 2: magnitude times gain
   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_neg_in   = s1_neg_ff;
      s2_prod_in  = {32'd0, s1_mag_ff} * {32'd0, gain_ff};
      s2_bend_in  = s1_bend_ff;
   end

   // stage 3: truncate toward zero, restore sign, pack bytes
   always_comb begin
      shifted = s2_prod_ff >> FRAC_BITS;
      scaled  = s2_neg_ff ? (~shifted[31:0] + 32'd1) : shifted[31:0];
      b0      = scaled[7:0];
      b1      = scaled[15:8];
      b2      = scaled[23:16];
      b3      = scaled[31:24];
      b2_sign = scaled[31] ? (b2 | pcmsp_pkg::SIGN_MASK) : b2;

      wr_en              = s2_valid_ff;
      wr_entry.block_end = s2_bend_ff;
      wr_entry.bytes     = {b3, b2, b1, b0};
      wr_entry.last_idx  = 2'd3;
      unique case (format_ff)
         pcmsp_pkg::FMT_U8: begin
            wr_entry.bytes[0] = b0 + offset_ff;
            wr_entry.last_idx = 2'd0;
         end
         pcmsp_pkg::FMT_S16_LE: begin
            wr_entry.last_idx = 2'd1;
         end
         pcmsp_pkg::FMT_S16_BE: begin
            wr_entry.bytes[0] = b1;
            wr_entry.bytes[1] = b0;
            wr_entry.last_idx = 2'd1;
         end
         pcmsp_pkg::FMT_S24_LE: begin
            wr_entry.bytes = {pcmsp_pkg::PAD_BYTE, b2_sign, b1, b0};
         end
         pcmsp_pkg::FMT_S24_BE: begin
            wr_entry.bytes = {b0, b1, b2_sign, pcmsp_pkg::PAD_BYTE};
         end
         pcmsp_pkg::FMT_S32_LE: begin
            wr_entry.bytes = {b3, b2, b1, b0};
         end
         pcmsp_pkg::FMT_S32_BE: begin
            wr_entry.bytes = {b0, b1, b2, b3};
         end
         default: begin
            // unused code: drop the sample
            wr_en = 1'b0;
         end
      endcase
   end

   assign inflight = {1'b0, s1_valid_ff} + {1'b0, s2_valid_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff    <= pcmsp_pkg::FORMAT_RESET;
         gain_ff      <= pcmsp_pkg::GAIN_RESET;
         offset_ff    <= pcmsp_pkg::OFFSET_RESET;
         clip_high_ff <= pcmsp_pkg::CLIP_HIGH_RESET;
         clip_low_ff  <= pcmsp_pkg::CLIP_LOW_RESET;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
      end else begin
         format_ff    <= format_in;
         gain_ff      <= gain_in;
         offset_ff    <= offset_in;
         clip_high_ff <= clip_high_in;
         clip_low_ff  <= clip_low_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_neg_ff  <= s1_neg_in;
      s1_mag_ff  <= s1_mag_in;
      s1_bend_ff <= s1_bend_in;
      s2_neg_ff  <= s2_neg_in;
      s2_prod_ff <= s2_prod_in;
      s2_bend_ff <= s2_bend_in;
   end

endmodule

FILE: sv/pcmsp_queue.sv
// Small queue of packed samples between the front end and the serializer.
module pcmsp_queue #(
   parameter int DEPTH = pcmsp_pkg::QUEUE_DEPTH_DEFAULT,
   localparam int PW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  pcmsp_pkg::entry_type wr_entry,
   input  logic                 rd_en,
   output pcmsp_pkg::entry_type rd_entry,
   output logic                 empty,
   output logic [CW-1:0]        count
);

   pcmsp_pkg::entry_type mem_ff [DEPTH];
   logic [PW-1:0] head_ff,  head_in;
   logic [PW-1:0] tail_ff,  tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_wr, do_rd;

   always_comb begin
      do_wr    = wr_en && (count_ff != CW'(DEPTH));
      do_rd    = rd_en && (count_ff != '0);
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_wr) begin
         tail_in = (tail_ff == PW'(DEPTH - 1)) ? '0 : tail_ff + PW'(1);
      end
      if (do_rd) begin
         head_in = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + PW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CW'(1);
      end
   end

   assign rd_entry = mem_ff[head_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[tail_ff] <= wr_entry;
      end
   end

endmodule

FILE: sv/pcmsp_back.sv
// Back end: serializes packed samples into single bytes behind an output register.
module pcmsp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  pcmsp_pkg::entry_type    q_entry,
   input  logic                    q_empty,
   output logic                    q_pop,
   output logic                    rsp_empty,
   output pcmsp_pkg::rsp_word_type rsp_data,
   input  logic                    rsp_pop
);

   logic                    cur_valid_ff, cur_valid_in;
   pcmsp_pkg::entry_type    cur_ff,       cur_in;
   logic [1:0]              idx_ff,       idx_in;
   logic                    out_valid_ff, out_valid_in;
   pcmsp_pkg::rsp_word_type out_ff,       out_in;
   logic                    out_load, cur_last;

   always_comb begin
      out_load     = cur_valid_ff && (!out_valid_ff || rsp_pop);
      cur_last     = (idx_ff == cur_ff.last_idx);
      q_pop        = !q_empty && (!cur_valid_ff || (out_load && cur_last));

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_load) begin
         out_valid_in         = 1'b1;
         out_in.out_byte      = cur_ff.bytes[idx_ff];
         out_in.last_byte     = cur_last;
         out_in.block_end_out = cur_last && cur_ff.block_end;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end

      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      if (q_pop) begin
         cur_valid_in = 1'b1;
         cur_in       = q_entry;
         idx_in       = 2'd0;
      end else if (out_load && cur_last) begin
         cur_valid_in = 1'b0;
      end else if (out_load) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

endmodule

FILE: sv/pcm_sample_packer_core.sv
// Top level of the PCM sample packer: front end, sample queue and byte serializer.
//  - Push one Q7.24 sample word on req_data with req_push while req_full is low.
//    The sample is clamped to [clip_low, clip_high], scaled by the gain register
//    (truncating toward zero) and packed for the selected format.
//  - Each packed byte leaves as one word on rsp_data while rsp_empty is low;
//    pop it with rsp_pop. The final byte of a sample has last_byte set and
//    carries block_end on block_end_out. Format code 7 produces no bytes.
//  - Write registers through csr_write_en / csr_index / csr_wdata only while
//    the block is drained; a write to an unknown index is dropped.
//  - The first byte of a sample passes the clamp and multiply registers, the queue
//    write, the serializer load and the output register before it can be popped.
//  - Throughput: one byte per cycle while rsp_pop stays high, set by the
//    single-byte output register; a sample is 1, 2 or 4 bytes depending on
//    format, so pushes may come back to back while the queue has room.
//  - When the consumer stalls the output word holds, the serializer and queue
//    fill, and req_full rises once queued plus in-flight samples reach the
//    queue depth; nothing is lost.
//  - Synchronous reset empties the pipeline and queue and restores all
//    registers to their defaults (format s16 le, gain 32768, offset 128,
//    limits +1.0 / -1.0).
module pcm_sample_packer_core #(
   parameter int FRAC_BITS   = pcmsp_pkg::FRAC_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = pcmsp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  pcmsp_pkg::req_word_type             req_data,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output pcmsp_pkg::rsp_word_type             rsp_data,
   input  logic                                csr_write_en,
   input  logic [pcmsp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pcmsp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic                 accept;
   logic                 wr_en;
   pcmsp_pkg::entry_type wr_entry;
   logic [1:0]           inflight;
   pcmsp_pkg::entry_type q_entry;
   logic                 q_empty, q_pop;
   logic [CW-1:0]        q_count;
   logic [CW:0]          pending;

   // reserve a queue slot for every sample still in the front pipeline
   assign pending  = {1'b0, q_count} + (CW + 1)'(inflight);
   assign req_full = (pending >= (CW + 1)'(QUEUE_DEPTH));
   assign accept   = req_push && !req_full;

   pcmsp_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .in_valid     (accept),
      .in_word      (req_data),
      .wr_en        (wr_en),
      .wr_entry     (wr_entry),
      .inflight     (inflight)
   );

   pcmsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_entry (wr_entry),
      .rd_en    (q_pop),
      .rd_entry (q_entry),
      .empty    (q_empty),
      .count    (q_count)
   );

   pcmsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_entry   (q_entry),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop)
   );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the PCM sample packer core.
`timescale 1ns / 100ps

module tb;
   import pcmsp_pkg::*;

   localparam int FRAC_BITS      = FRAC_BITS_DEFAULT;
   localparam int RESET_CYCLES   = 6;
   localparam int SETTLE_CYCLES  = 12;      // settle time that lets a format-7 sample still in the pipe run out
   localparam int LONG_HOLD      = 60;      // receiver hold-off that fills the queue
   localparam int CYCLE_LIMIT    = 200000;
   localparam int PHASES         = 8;
   localparam int ITEMS_PER_PHASE = 13;
   localparam int NUM_DIRECTED   = 24;

   // format code that the block leaves unused: it emits nothing
   localparam logic [2:0] FMT_UNUSED = 3'd7;
   // register indexes past the last register: writes there are dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_UNUSED = CSR_CLIP_LOW + 1'b1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_INDEX   = '1;

   localparam logic [31:0]        GAIN_TOP  = 32'h8000_0000;
   localparam logic signed [31:0] CLIP_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] CLIP_MIN  = 32'sh8000_0000;
   localparam logic signed [31:0] ONE_Q24   = 32'sh0100_0000;
   localparam logic signed [31:0] M_ONE_Q24 = -32'sh0100_0000;

   // how the expected bytes of one sample are obtained: typed in, or predicted
   typedef struct packed {
      logic        known;
      logic [2:0]  nb;
      logic [31:0] bytes;    // byte k of the send order in bits [8k+7:8k]
   } typed_form_type;

   localparam typed_form_type PREDICT_FORM = '0;

   typedef struct packed {
      logic [2:0]  fmt;
      logic [31:0] gain;
      logic [7:0]  offset;
      logic [31:0] clip_hi;
      logic [31:0] clip_lo;
      logic [31:0] sample;
      logic        bend;
      logic        known;
      logic [2:0]  nb;
      logic [31:0] bytes;
   } case_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_push = 1'b0;
   logic                       req_full;
   req_word_type               req_data = '0;
   logic                       rsp_empty;
   logic                       rsp_pop = 1'b0;
   rsp_word_type               rsp_data;
   logic                       csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   // register image kept in step with every write the block accepts
   logic [2:0]         fmt_now     = FORMAT_RESET;
   logic [31:0]        gain_now    = GAIN_RESET;
   logic [7:0]         offset_now  = OFFSET_RESET;
   logic signed [31:0] clip_hi_now = CLIP_HIGH_RESET;
   logic signed [31:0] clip_lo_now = CLIP_LOW_RESET;

   rsp_word_type   pending_bytes[$];   // bytes still owed by the block, oldest first
   typed_form_type sent_forms[$];      // one per offered sample, in push order

   int  mismatch_count = 0;
   int  cycle_count = 0;
   bit  quiet = 1'b0;                  // no idling on either side
   bit  steady = 1'b0;                 // sender offers back to back
   int  hold_asks = 0;
   int  hold_done = 0;
   int  hold_left = 0;
   int  pop_gap = 0;

   pcm_sample_packer_core DUT (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_data     (req_data),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #10 clock = ~clock;

   // Clamp, scale by the gain and truncate toward zero; the result wraps to 32 bits.
   function automatic logic [31:0] scale_q24(input logic signed [31:0] raw);
      logic signed [31:0] s;
      logic signed [63:0] wide;
      logic [63:0]        mag;
      logic [63:0]        q;
      s = raw;
      // the upper limit wins when the limits are crossed
      if (s > clip_hi_now) begin
         s = clip_hi_now;
      end else if (s < clip_lo_now) begin
         s = clip_lo_now;
      end
      wide = s;
      mag = (wide < 0) ? -wide : wide;
      q = (mag * {32'd0, gain_now}) >> FRAC_BITS;
      if (wide < 0) begin
         q = -q;
      end
      return q[31:0];
   endfunction

   // Pack one sample for the current format; nb is the number of bytes sent.
   function automatic logic [31:0] pack_sample(input logic [31:0] raw, output int nb);
      logic [31:0] w;
      logic [7:0]  b2;
      w = scale_q24(raw);
      // 24-bit formats force the sign bit on negatives
      b2 = w[23:16] | (w[31] ? SIGN_MASK : 8'h00);
      case (fmt_now)
         FMT_U8: begin
            nb = 1;
            return {24'd0, w[7:0] + offset_now};
         end
         FMT_S16_LE: begin
            nb = 2;
            return {16'd0, w[15:8], w[7:0]};
         end
         FMT_S16_BE: begin
            nb = 2;
            return {16'd0, w[7:0], w[15:8]};
         end
         FMT_S24_LE: begin
            nb = 4;
            return {PAD_BYTE, b2, w[15:8], w[7:0]};
         end
         FMT_S24_BE: begin
            nb = 4;
            return {w[7:0], w[15:8], b2, PAD_BYTE};
         end
         FMT_S32_LE: begin
            nb = 4;
            return w;
         end
         FMT_S32_BE: begin
            nb = 4;
            return {w[7:0], w[15:8], w[23:16], w[31:24]};
         end
         default: begin
            nb = 0;
            return 32'd0;
         end
      endcase
   endfunction

   // Sample both channels at the rising edge: queue the bytes of each accepted
   // sample, and check each popped word against the oldest owed byte.
   always @(posedge clock) begin
      typed_form_type form;
      logic [31:0]    bytes;
      int             nb;
      rsp_word_type   owed;
      if (!reset) begin
         if (req_push && !req_full) begin
            form = (sent_forms.size() != 0) ? sent_forms.pop_front() : PREDICT_FORM;
            if (form.known) begin
               nb = form.nb;
               bytes = form.bytes;
            end else begin
               bytes = pack_sample(req_data.sample_value, nb);
            end
            for (int k = 0; k < nb; k++) begin
               owed.out_byte      = bytes[8*k +: 8];
               owed.last_byte     = (k == nb - 1);
               owed.block_end_out = (k == nb - 1) && req_data.block_end;
               pending_bytes.push_back(owed);
            end
         end
         if (rsp_pop && !rsp_empty) begin
            if (pending_bytes.size() == 0) begin
               $display("%0t: word with nothing owed: expected none, actual %h",
                        $time, rsp_data);
               mismatch_count++;
            end else begin
               owed = pending_bytes.pop_front();
               if (rsp_data.out_byte !== owed.out_byte) begin
                  $display("%0t: out_byte expected %h, actual %h",
                           $time, owed.out_byte, rsp_data.out_byte);
                  mismatch_count++;
               end
               if (rsp_data.last_byte !== owed.last_byte) begin
                  $display("%0t: last_byte expected %b, actual %b",
                           $time, owed.last_byte, rsp_data.last_byte);
                  mismatch_count++;
               end
               if (rsp_data.block_end_out !== owed.block_end_out) begin
                  $display("%0t: block_end_out expected %b, actual %b",
                           $time, owed.block_end_out, rsp_data.block_end_out);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Receiver: pop at the falling edge, with random stall bursts and, on
   // request, one long hold-off counted here.
   always @(negedge clock) begin
      if (hold_done != hold_asks) begin
         hold_done = hold_asks;
         hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else if (pop_gap != 0) begin
         pop_gap--;
         rsp_pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         pop_gap = $urandom_range(1, 13) - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // Bound the run in case the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // Offer one sample word and hold it until the block takes it. Enter and
   // leave at a falling edge; push stays high on return.
   task automatic send_word(input logic [31:0] s, input logic bend,
                            input typed_form_type form);
      if (!quiet && !steady && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      sent_forms.push_back(form);
      req_push <= 1'b1;
      req_data <= '{sample_value: s, block_end: bend};
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop push and wait until every owed byte has left, then let any
   // format-7 sample still in the pipe run out.
   task automatic wait_idle();
      req_push <= 1'b0;
      while (pending_bytes.size() != 0 || sent_forms.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Drive one register write; leave the enable high for the caller to drop.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      case (idx)
         CSR_FORMAT:    fmt_now = data[2:0];
         CSR_GAIN:      gain_now = data;
         CSR_OFFSET:    offset_now = data[7:0];
         CSR_CLIP_HIGH: clip_hi_now = data;
         CSR_CLIP_LOW:  clip_lo_now = data;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Drain, then load all five registers plus one write to a dead index.
   task automatic apply_settings(input logic [2:0] fmt, input logic [31:0] gain,
                                 input logic [7:0] offset, input logic [31:0] hi,
                                 input logic [31:0] lo);
      wait_idle();
      write_reg(CSR_FORMAT, {29'd0, fmt});
      write_reg(CSR_GAIN, gain);
      write_reg(CSR_OFFSET, {24'd0, offset});
      write_reg(CSR_CLIP_HIGH, hi);
      write_reg(CSR_CLIP_LOW, lo);
      write_reg(CSR_INDEX_W'($urandom_range(CSR_FIRST_UNUSED, CSR_LAST_INDEX)), $urandom);
      csr_write_en <= 1'b0;
   endtask

   // Directed cases. Bytes are in send order, first byte in the low bits;
   // rows with known = 0 go through the predictor.
   case_row_type dir_plan [0:NUM_DIRECTED-1] = '{
      // reset settings: s16 le, gain 32768, limits +/-1.0
      '{FMT_S16_LE, GAIN_RESET, OFFSET_RESET, CLIP_HIGH_RESET, CLIP_LOW_RESET,
        ONE_Q24, 1'b0, 1'b1, 3'd2, 32'h0000_8000},
      '{FMT_S16_LE, GAIN_RESET, OFFSET_RESET, CLIP_HIGH_RESET, CLIP_LOW_RESET,
        32'h0000_0000, 1'b1, 1'b1, 3'd2, 32'h0000_0000},
      '{FMT_S16_LE, GAIN_RESET, OFFSET_RESET, CLIP_HIGH_RESET, CLIP_LOW_RESET,
        M_ONE_Q24, 1'b0, 1'b1, 3'd2, 32'h0000_8000},
      // clamp at both limits, then half scale
      '{FMT_S16_LE, GAIN_RESET, OFFSET_RESET, CLIP_HIGH_RESET, CLIP_LOW_RESET,
        CLIP_MAX, 1'b0, 1'b1, 3'd2, 32'h0000_8000},
      '{FMT_S16_LE, GAIN_RESET, OFFSET_RESET, CLIP_HIGH_RESET, CLIP_LOW_RESET,
        CLIP_MIN, 1'b1, 1'b1, 3'd2, 32'h0000_8000},
      '{FMT_S16_LE, GAIN_RESET, OFFSET_RESET, CLIP_HIGH_RESET, CLIP_LOW_RESET,
        32'h0080_0000, 1'b0, 1'b1, 3'd2, 32'h0000_4000},
      // big endian, and truncation of a tiny negative to zero
      '{FMT_S16_BE, GAIN_RESET, OFFSET_RESET, CLIP_HIGH_RESET, CLIP_LOW_RESET,
        32'h0080_0000, 1'b0, 1'b1, 3'd2, 32'h0000_0040},
      '{FMT_S16_BE, GAIN_RESET, OFFSET_RESET, CLIP_HIGH_RESET, CLIP_LOW_RESET,
        32'hFFFF_FFFF, 1'b1, 1'b1, 3'd2, 32'h0000_0000},
      // u8 with the usual offset
      '{FMT_U8, 32'd127, OFFSET_RESET, CLIP_HIGH_RESET, CLIP_LOW_RESET,
        ONE_Q24, 1'b0, 1'b1, 3'd1, 32'h0000_00FF},
      '{FMT_U8, 32'd127, OFFSET_RESET, CLIP_HIGH_RESET, CLIP_LOW_RESET,
        M_ONE_Q24, 1'b1, 1'b1, 3'd1, 32'h0000_0001},
      '{FMT_U8, 32'd127, OFFSET_RESET, CLIP_HIGH_RESET, CLIP_LOW_RESET,
        32'h0000_0000, 1'b0, 1'b1, 3'd1, 32'h0000_0080},
      // zero gain, offset at both ends
      '{FMT_U8, 32'd0, 8'hFF, CLIP_HIGH_RESET, CLIP_LOW_RESET,
        32'h5A5A_5A5A, 1'b1, 1'b1, 3'd1, 32'h0000_00FF},
      '{FMT_U8, 32'd0, 8'h00, CLIP_HIGH_RESET, CLIP_LOW_RESET,
        32'hA5A5_A5A5, 1'b0, 1'b1, 3'd1, 32'h0000_0000},
      // 24 bit little endian with pad byte
      '{FMT_S24_LE, 32'h007F_FFFF, OFFSET_RESET, CLIP_HIGH_RESET, CLIP_LOW_RESET,
        ONE_Q24, 1'b0, 1'b1, 3'd4, 32'h007F_FFFF},
      '{FMT_S24_LE, 32'h007F_FFFF, OFFSET_RESET, CLIP_HIGH_RESET, CLIP_LOW_RESET,
        M_ONE_Q24, 1'b1, 1'b1, 3'd4, 32'h0080_0001},
      // 24 bit big endian; last row has the sign bit forced into b2
      '{FMT_S24_BE, 32'h0080_0000, OFFSET_RESET, CLIP_HIGH_RESET, CLIP_LOW_RESET,
        ONE_Q24, 1'b0, 1'b1, 3'd4, 32'h0000_8000},
      '{FMT_S24_BE, 32'h0080_0000, OFFSET_RESET, CLIP_HIGH_RESET, CLIP_LOW_RESET,
        M_ONE_Q24, 1'b0, 1'b1, 3'd4, 32'h0000_8000},
      '{FMT_S24_BE, 32'h0100_0000, OFFSET_RESET, CLIP_MAX, CLIP_MIN,
        32'hF012_3456, 1'b1, 1'b1, 3'd4, 32'h5634_9200},
      // full range and top gain: the product wraps
      '{FMT_S32_LE, GAIN_TOP, OFFSET_RESET, CLIP_MAX, CLIP_MIN,
        CLIP_MAX, 1'b0, 1'b0, 3'd0, 32'd0},
      '{FMT_S32_LE, GAIN_TOP, OFFSET_RESET, CLIP_MAX, CLIP_MIN,
        CLIP_MIN, 1'b1, 1'b0, 3'd0, 32'd0},
      '{FMT_S32_BE, 32'hFFFF_FFFF, OFFSET_RESET, CLIP_MAX, CLIP_MIN,
        32'h1234_5678, 1'b0, 1'b0, 3'd0, 32'd0},
      // crossed limits: upper limit tested first
      '{FMT_S32_LE, 32'h0100_0000, OFFSET_RESET, M_ONE_Q24, ONE_Q24,
        32'h0200_0000, 1'b1, 1'b1, 3'd4, 32'hFF00_0000},
      '{FMT_S32_LE, 32'h0100_0000, OFFSET_RESET, M_ONE_Q24, ONE_Q24,
        32'hFE00_0000, 1'b0, 1'b1, 3'd4, 32'h0100_0000},
      // unused format code: nothing comes out
      '{FMT_UNUSED, GAIN_RESET, OFFSET_RESET, CLIP_HIGH_RESET, CLIP_LOW_RESET,
        ONE_Q24, 1'b1, 1'b1, 3'd0, 32'd0}
   };

   initial begin
      case_row_type       row;
      int                 n_items;
      logic [2:0]         fmt_pick;
      logic [31:0]        gain_pick;
      logic signed [31:0] hi_pick;
      logic signed [31:0] lo_pick;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic [31:0]        s;

      // hold reset, then release it on a falling edge
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // walk the table; reload the registers only where a row changes them
      foreach (dir_plan[r]) begin
         row = dir_plan[r];
         if (row.fmt != fmt_now || row.gain != gain_now || row.offset != offset_now ||
             row.clip_hi != clip_hi_now || row.clip_lo != clip_lo_now) begin
            apply_settings(row.fmt, row.gain, row.offset, row.clip_hi, row.clip_lo);
         end
         send_word(row.sample, row.bend, '{row.known, row.nb, row.bytes});
      end
      send_word($urandom, 1'b0, PREDICT_FORM);   // a second word under format 7

      // random phases, each under its own settings
      for (int ph = 0; ph < PHASES; ph++) begin
         quiet  = (ph == PHASES - 1);
         steady = (ph == 1);
         fmt_pick = (ph == 4) ? FMT_UNUSED : 3'($urandom_range(FMT_U8, FMT_S32_BE));
         case ($urandom_range(0, 3))
            0:       gain_pick = $urandom;
            1:       gain_pick = $urandom_range(0, 65535);
            2:       gain_pick = 32'd1 << $urandom_range(0, 31);
            default: gain_pick = GAIN_TOP;
         endcase
         case ($urandom_range(0, 3))
            0: begin
               a = $urandom;
               b = $urandom;
               hi_pick = (a > b) ? a : b;
               lo_pick = (a > b) ? b : a;
            end
            1: begin
               hi_pick = CLIP_MAX;
               lo_pick = CLIP_MIN;
            end
            2: begin
               // may come out crossed
               hi_pick = $urandom;
               lo_pick = $urandom;
            end
            default: begin
               hi_pick = CLIP_HIGH_RESET;
               lo_pick = CLIP_LOW_RESET;
            end
         endcase
         apply_settings(fmt_pick, gain_pick, 8'($urandom), hi_pick, lo_pick);

         // stall the receiver for a long stretch while words keep coming
         if (steady) begin
            hold_asks++;
         end
         n_items = (fmt_pick == FMT_UNUSED) ? 4 : ITEMS_PER_PHASE;
         for (int i = 0; i < n_items; i++) begin
            // pause the sender mid-phase until the block has drained
            if (ph == 2 && i == n_items / 2) begin
               wait_idle();
            end
            case ($urandom_range(0, 4))
               0, 1: s = $urandom;
               2:    s = (($urandom_range(0, 1) != 0) ? clip_hi_now : clip_lo_now)
                         + 32'($urandom_range(0, 8)) - 32'd4;
               3:    s = 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
               default: begin
                  case ($urandom_range(0, 3))
                     0:       s = CLIP_MAX;
                     1:       s = CLIP_MIN;
                     2:       s = 32'h0000_0000;
                     default: s = 32'hFFFF_FFFF;
                  endcase
               end
            endcase
            send_word(s, 1'($urandom_range(0, 1)), PREDICT_FORM);
         end
      end

      // flush and report
      wait_idle();
      if (mismatch_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

FILE: pcm_sample_packer_core.f
sv/pcmsp_pkg.sv
sv/pcmsp_front.sv
sv/pcmsp_queue.sv
sv/pcmsp_back.sv
sv/pcm_sample_packer_core.sv
tb/tb.sv
